FILE: sv/gte_pkg.sv
package gte_pkg;

	// Fixed widths of the block.
	localparam int SAMPLE_BITS    = 24;
	localparam int COUNT_BITS     = 20;
	localparam int GAIN_FRAC_BITS = 15;
	localparam int GAIN_BITS      = GAIN_FRAC_BITS + 2;
	localparam int REM_BITS       = COUNT_BITS + 1;
	localparam int SLOPE_BITS     = 16;
	localparam int Q15_BITS       = 16;
	localparam int CFG_IDX_BITS   = 3;
	localparam int MUL_A_BITS     = 27;
	localparam int MUL_B_BITS     = 22;
	localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS;
	localparam int MIX_BITS       = SAMPLE_BITS + 2;
	localparam int TRUNC_BITS     = PROD_BITS - GAIN_FRAC_BITS;
	localparam int DIV_STEPS      = GAIN_FRAC_BITS;
	localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS + 1);

	localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;
	localparam logic [Q15_BITS:0] Q15_ONE = 17'd32768;

	// Reciprocal of three for inputs below 2^21: x / 3 = (x * RECIP3) >> RECIP3_SHIFT.
	localparam int RECIP3_SHIFT = REM_BITS;
	localparam logic [MUL_B_BITS-1:0] RECIP3 = MUL_B_BITS'(((64'd1 << RECIP3_SHIFT) + 1) / 3);

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_CYCLE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SLOPE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PAN   = 3'd4;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [GAIN_BITS-1:0]          gain_t;
	typedef logic [COUNT_BITS-1:0]         count_t;
	typedef logic [REM_BITS-1:0]           rem_t;

	typedef enum logic [1:0] {
		PH_SLOPE_IN  = 2'd0,
		PH_PLATEAU   = 2'd1,
		PH_SLOPE_OUT = 2'd2,
		PH_VALLEY    = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_SQ, ST_BASE, ST_AMP, ST_NC1, ST_NC2,
		ST_MIX_L, ST_MIX_R, ST_GAIN_L, ST_GAIN_R, ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		MUL_SQ, MUL_BASE, MUL_DIV3, MUL_PAN,
		MUL_MIX_L, MUL_MIX_R, MUL_GAIN_L, MUL_GAIN_R
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_step;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     amp_ld;
		logic     adv;
		logic     slp3_ld;
		logic     nc_ld;
		logic     mix_l_ld;
		logic     mix_r_ld;
		logic     out_l_ld;
		logic     fin;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic valley_done;
		logic out_free;
	} status_t;

	// Divide a signed product by unity, rounding toward zero.
	function automatic logic signed [TRUNC_BITS-1:0] trunc_gain(
		input logic signed [PROD_BITS-1:0] p);
		logic signed [PROD_BITS-1:0] adj;
		adj = p[PROD_BITS-1] ? p + PROD_BITS'((64'd1 << GAIN_FRAC_BITS) - 1) : p;
		return TRUNC_BITS'(adj >>> GAIN_FRAC_BITS);
	endfunction

	// Clamp to the signed sample range.
	function automatic sample_t sat_sample(input logic signed [TRUNC_BITS-1:0] v);
		logic signed [TRUNC_BITS-1:0] hi;
		logic signed [TRUNC_BITS-1:0] lo;
		hi = TRUNC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
		lo = -hi - TRUNC_BITS'(1);
		if (v > hi) return sample_t'(hi);
		else if (v < lo) return sample_t'(lo);
		else return sample_t'(v);
	endfunction

endpackage

FILE: sv/gte_if.sv
interface gte_in_if;
	logic              valid;
	logic              ready;
	gte_pkg::sample_t  sample_left;
	gte_pkg::sample_t  sample_right;
	logic signed [15:0] pan_random;

	modport source (output valid, sample_left, sample_right, pan_random, input ready);
	modport sink (input valid, sample_left, sample_right, pan_random, output ready);
endinterface

interface gte_out_if;
	logic             valid;
	logic             ready;
	gte_pkg::sample_t out_left;
	gte_pkg::sample_t out_right;
	logic [1:0]       phase_now;

	modport source (output valid, out_left, out_right, phase_now, input ready);
	modport sink (input valid, out_left, out_right, phase_now, output ready);
endinterface

FILE: sv/gte_ctrl.sv
module gte_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gte_pkg::status_t status,
	output gte_pkg::cmd_t    cmd
);
	import gte_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_nxt = ST_DIV;
			ST_DIV:     if (!status.div_busy) state_nxt = ST_SQ;
			ST_SQ:      state_nxt = ST_BASE;
			ST_BASE:    state_nxt = ST_AMP;
			ST_AMP:     state_nxt = status.valley_done ? ST_NC1 : ST_MIX_L;
			ST_NC1:     state_nxt = ST_NC2;
			ST_NC2:     state_nxt = ST_MIX_L;
			ST_MIX_L:   state_nxt = ST_MIX_R;
			ST_MIX_R:   state_nxt = ST_GAIN_L;
			ST_GAIN_L:  state_nxt = ST_GAIN_R;
			ST_GAIN_R:  state_nxt = ST_FIN;
			ST_FIN:     if (status.out_free) state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_SQ;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV:  cmd.div_step = status.div_busy;
			ST_SQ: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_SQ;
			end
			ST_BASE: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_BASE;
			end
			ST_AMP: begin
				cmd.amp_ld = 1'b1;
				cmd.adv = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_DIV3;
			end
			ST_NC1: begin
				cmd.slp3_ld = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_PAN;
			end
			ST_NC2:  cmd.nc_ld = 1'b1;
			ST_MIX_L: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_MIX_L;
			end
			ST_MIX_R: begin
				cmd.mix_l_ld = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_MIX_R;
			end
			ST_GAIN_L: begin
				cmd.mix_r_ld = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_GAIN_L;
			end
			ST_GAIN_R: begin
				cmd.out_l_ld = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_GAIN_R;
			end
			ST_FIN:  cmd.fin = status.out_free;
			default: cmd = '0;
		endcase
	end

	// An accepted word always starts the divide phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> state_q == ST_DIV)
		else $error("accepted word did not start processing");

	// New-cycle setup is only entered from the amplitude step.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NC1 |-> $past(state_q) == ST_AMP)
		else $error("new-cycle setup entered out of order");

	// The divider is idle whenever the block waits for a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !status.div_busy)
		else $error("divider busy while idle");

endmodule

FILE: sv/gte_dp.sv
module gte_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gte_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [gte_pkg::COUNT_BITS-1:0]       cfg_data,
	input  gte_pkg::sample_t                     in_left,
	input  gte_pkg::sample_t                     in_right,
	input  logic signed [15:0]                   in_rnd,
	input  gte_pkg::cmd_t                        cmd,
	output gte_pkg::status_t                     status,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output gte_pkg::sample_t                     out_left,
	output gte_pkg::sample_t                     out_right,
	output logic [1:0]                           out_phase
);
	import gte_pkg::*;

	// Configuration registers.
	count_t                 cycle_q;
	count_t                 pulse_q;
	logic [SLOPE_BITS-1:0]  slope_q;
	logic [Q15_BITS-1:0]    floor_q;
	logic [Q15_BITS-1:0]    panw_q;

	// Envelope state.
	phase_t  phase_q;
	rem_t    remain_q;
	count_t  slope_use_q;
	rem_t    plat_use_q;
	rem_t    valley_use_q;
	gain_t   pan_l_q;
	gain_t   pan_r_q;

	// Per-word working registers.
	sample_t                     left_q;
	sample_t                     right_q;
	logic signed [15:0]          rnd_q;
	logic [Q15_BITS-1:0]         quot_q;
	count_t                      div_rem_q;
	logic [DIV_CNT_BITS-1:0]     div_cnt_q;
	logic signed [PROD_BITS-1:0] prod_q;
	gain_t                       amp_q;
	count_t                      slp3_q;
	logic signed [MIX_BITS-1:0]  mix_l_q;
	logic signed [MIX_BITS-1:0]  mix_r_q;
	sample_t                     res_l_q;
	logic                        out_valid_q;
	sample_t                     out_l_q;
	sample_t                     out_r_q;
	phase_t                      out_phase_q;

	gain_t                       floor_g;
	gain_t                       panw_g;
	logic                        done;
	rem_t                        n_val;
	count_t                      pul;
	logic signed [MUL_A_BITS-1:0] mul_a;
	logic signed [MUL_B_BITS-1:0] mul_b;
	logic signed [TRUNC_BITS-1:0] prod_tr;
	rem_t                        div_sh;
	logic signed [REM_BITS:0]    plat0;
	count_t                      slp_new;
	logic signed [Q15_BITS+1:0]  pan_s;

	assign floor_g = (floor_q > Q15_ONE[Q15_BITS-1:0] && floor_q[Q15_BITS-1]) ?
		UNITY : gain_t'(floor_q);
	assign panw_g = (panw_q > Q15_ONE[Q15_BITS-1:0] && panw_q[Q15_BITS-1]) ?
		UNITY : gain_t'(panw_q);
	assign done = remain_q <= rem_t'(1);
	assign pul = (pulse_q > cycle_q) ? cycle_q : pulse_q;
	assign prod_tr = trunc_gain(prod_q);
	assign div_sh = {div_rem_q, 1'b0};

	// Slope sample count for the current phase: elapsed samples in the rising slope, remaining samples otherwise.
	always_comb begin
		if (phase_q == PH_SLOPE_IN)
			n_val = rem_t'(slope_use_q) -
				((remain_q < rem_t'(slope_use_q)) ? remain_q : rem_t'(slope_use_q));
		else
			n_val = remain_q;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q <= count_t'(44100);
			pulse_q <= count_t'(22050);
			slope_q <= SLOPE_BITS'(441);
			floor_q <= '0;
			panw_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CYCLE: cycle_q <= cfg_data;
				CFG_PULSE: pulse_q <= cfg_data;
				CFG_SLOPE: slope_q <= cfg_data[SLOPE_BITS-1:0];
				CFG_FLOOR: floor_q <= cfg_data[Q15_BITS-1:0];
				CFG_PAN:   panw_q  <= cfg_data[Q15_BITS-1:0];
				default:   ;
			endcase
		end
	end

	// Serial divider for the slope fraction, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			if ((phase_q == PH_SLOPE_IN || phase_q == PH_SLOPE_OUT) &&
			    slope_use_q != '0 && n_val < rem_t'(slope_use_q))
				div_cnt_q <= DIV_CNT_BITS'(DIV_STEPS);
			else
				div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q    <= in_left;
			right_q   <= in_right;
			rnd_q     <= in_rnd;
			div_rem_q <= n_val[COUNT_BITS-1:0];
			if (slope_use_q == '0) quot_q <= '0;
			else if (n_val >= rem_t'(slope_use_q)) quot_q <= Q15_ONE[Q15_BITS-1:0];
			else quot_q <= '0;
		end else if (cmd.div_step) begin
			if (div_sh >= rem_t'(slope_use_q)) begin
				div_rem_q <= count_t'(div_sh - rem_t'(slope_use_q));
				quot_q    <= {quot_q[Q15_BITS-2:0], 1'b1};
			end else begin
				div_rem_q <= div_sh[COUNT_BITS-1:0];
				quot_q    <= {quot_q[Q15_BITS-2:0], 1'b0};
			end
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_SQ: begin
				mul_a = MUL_A_BITS'(quot_q);
				mul_b = MUL_B_BITS'(quot_q);
			end
			MUL_BASE: begin
				mul_a = MUL_A_BITS'(prod_q[GAIN_FRAC_BITS+GAIN_BITS-1:GAIN_FRAC_BITS]);
				mul_b = MUL_B_BITS'(UNITY - floor_g);
			end
			MUL_DIV3: begin
				mul_a = MUL_A_BITS'(rem_t'(pul) + rem_t'(1));
				mul_b = RECIP3;
			end
			MUL_PAN: begin
				mul_a = MUL_A_BITS'(rnd_q);
				mul_b = MUL_B_BITS'(panw_g);
			end
			MUL_MIX_L: begin
				mul_a = (pan_l_q <= UNITY) ? MUL_A_BITS'(left_q) : MUL_A_BITS'(right_q);
				mul_b = (pan_l_q <= UNITY) ? MUL_B_BITS'(pan_l_q) :
					MUL_B_BITS'(pan_l_q - UNITY);
			end
			MUL_MIX_R: begin
				mul_a = (pan_r_q <= UNITY) ? MUL_A_BITS'(right_q) : MUL_A_BITS'(left_q);
				mul_b = (pan_r_q <= UNITY) ? MUL_B_BITS'(pan_r_q) :
					MUL_B_BITS'(pan_r_q - UNITY);
			end
			MUL_GAIN_L: begin
				mul_a = MUL_A_BITS'(mix_l_q);
				mul_b = MUL_B_BITS'(amp_q);
			end
			MUL_GAIN_R: begin
				mul_a = MUL_A_BITS'(mix_r_q);
				mul_b = MUL_B_BITS'(amp_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Product register and per-word results.
	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_q <= mul_a * mul_b;
		if (cmd.amp_ld) begin
			if (phase_q == PH_SLOPE_IN || phase_q == PH_SLOPE_OUT)
				amp_q <= floor_g + prod_q[GAIN_FRAC_BITS+GAIN_BITS-1:GAIN_FRAC_BITS];
			else if (phase_q == PH_PLATEAU)
				amp_q <= UNITY;
			else
				amp_q <= floor_g;
		end
		if (cmd.slp3_ld) slp3_q <= prod_q[RECIP3_SHIFT+COUNT_BITS-1:RECIP3_SHIFT];
		if (cmd.mix_l_ld) begin
			if (pan_l_q <= UNITY) mix_l_q <= MIX_BITS'(prod_tr);
			else mix_l_q <= MIX_BITS'(left_q) + MIX_BITS'(prod_tr);
		end
		if (cmd.mix_r_ld) begin
			if (pan_r_q <= UNITY) mix_r_q <= MIX_BITS'(prod_tr);
			else mix_r_q <= MIX_BITS'(right_q) + MIX_BITS'(prod_tr);
		end
		if (cmd.out_l_ld) res_l_q <= sat_sample(prod_tr);
	end

	// Next-cycle phase lengths.
	assign plat0 = $signed({2'b0, pul}) - $signed({5'b0, slope_q, 1'b0});
	assign slp_new = (plat0 < $signed((REM_BITS+1)'(1))) ? slp3_q : count_t'(slope_q);
	assign pan_s = (REM_BITS - 3)'(prod_tr);

	// Envelope state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_VALLEY;
			remain_q     <= '0;
			slope_use_q  <= '0;
			plat_use_q   <= '0;
			valley_use_q <= '0;
			pan_l_q      <= UNITY;
			pan_r_q      <= UNITY;
		end else if (cmd.nc_ld) begin
			valley_use_q <= rem_t'(cycle_q - pul);
			slope_use_q  <= slp_new;
			plat_use_q   <= rem_t'(pul) - {slp_new, 1'b0};
			if (slp_new != '0) begin
				phase_q  <= PH_SLOPE_IN;
				remain_q <= rem_t'(slp_new);
			end else begin
				phase_q  <= PH_PLATEAU;
				remain_q <= rem_t'(pul) - {slp_new, 1'b0};
			end
			pan_l_q <= gain_t'($signed({2'b0, UNITY}) + pan_s);
			pan_r_q <= gain_t'($signed({2'b0, UNITY}) - pan_s);
		end else if (cmd.adv) begin
			if (!done) begin
				remain_q <= remain_q - rem_t'(1);
			end else begin
				case (phase_q)
					PH_SLOPE_IN: begin
						phase_q  <= PH_PLATEAU;
						remain_q <= plat_use_q;
					end
					PH_PLATEAU: begin
						if (slope_use_q != '0) begin
							phase_q  <= PH_SLOPE_OUT;
							remain_q <= rem_t'(slope_use_q);
						end else begin
							phase_q  <= PH_VALLEY;
							remain_q <= valley_use_q;
						end
					end
					PH_SLOPE_OUT: begin
						phase_q  <= PH_VALLEY;
						remain_q <= valley_use_q;
					end
					default: ;
				endcase
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.fin) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_l_q     <= res_l_q;
			out_r_q     <= sat_sample(prod_tr);
			out_phase_q <= phase_q;
		end
	end

	assign status.div_busy    = div_cnt_q != '0;
	assign status.valley_done = phase_q == PH_VALLEY && done;
	assign status.out_free    = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_left  = out_l_q;
	assign out_right = out_r_q;
	assign out_phase = out_phase_q;

	// The divider count never exceeds its number of divide steps.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_cnt_q <= DIV_CNT_BITS'(DIV_STEPS))
		else $error("divider count out of range");

	// A slope phase always has a nonzero slope length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SLOPE_IN || phase_q == PH_SLOPE_OUT) |-> slope_use_q != '0)
		else $error("slope phase with zero length");

	// The two pan gains always sum to twice unity.
	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, pan_l_q} + {1'b0, pan_r_q}) == {UNITY, 1'b0})
		else $error("pan gains out of balance");

endmodule

FILE: sv/gated_tremolo_envelope_core.sv
// An accepted input word passes through the divide, square, base, amplitude, mix,
// gain and finish states; the slope phases add the bit-serial divider steps and
// a new envelope cycle adds the setup states; words are handled one at a time.
// The output register lets the next word be accepted while a result waits.
// Reset (arst_n low, asynchronous) restores the default configuration,
// puts the envelope in the valley with zero count and sets both pan gains to unity.
module gated_tremolo_envelope_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gte_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [gte_pkg::COUNT_BITS-1:0]   cfg_data,
	gte_in_if.sink                           in_ch,
	gte_out_if.source                        out_ch
);
	import gte_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	assign in_ch.ready = in_ready;

	// Sequencer.
	gte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Envelope, pan and gain arithmetic.
	gte_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_left   (in_ch.sample_left),
		.in_right  (in_ch.sample_right),
		.in_rnd    (in_ch.pan_random),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_left  (out_ch.out_left),
		.out_right (out_ch.out_right),
		.out_phase (out_ch.phase_now)
	);

endmodule
